@@ hw/rtl/jsu_pkg.sv @@
`timescale 1ns / 1ps

package jsu_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam logic [15:0] CAP_RESET = 16'd256;

    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_U      = 8'h75;

    // Results of one input item: up to four bytes, bytes[0] goes out first
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      count;
        logic            is_done;
        logic            decode_ok;
    } jsu_group_t;

    // {valid, nibble}
    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [4:0] r;
        begin
            r = 5'd0;
            if (b >= 8'h30 && b <= 8'h39)
                r = {1'b1, 4'(b - 8'h30)};
            else if (b >= 8'h61 && b <= 8'h66)
                r = {1'b1, 4'(b - 8'h57)};
            else if (b >= 8'h41 && b <= 8'h46)
                r = {1'b1, 4'(b - 8'h37)};
            return r;
        end
    endfunction

    // {valid, byte}
    function automatic logic [8:0] simple_escape(input logic [7:0] b);
        logic [8:0] r;
        begin
            case (b)
                8'h22, 8'h5c, 8'h2f: r = {1'b1, b};
                8'h62:               r = {1'b1, 8'h08};
                8'h66:               r = {1'b1, 8'h0c};
                8'h6e:               r = {1'b1, 8'h0a};
                8'h72:               r = {1'b1, 8'h0d};
                8'h74:               r = {1'b1, 8'h09};
                default:             r = 9'd0;
            endcase
            return r;
        end
    endfunction

    function automatic jsu_group_t utf8_encode(input logic [20:0] cp);
        jsu_group_t g;
        begin
            g = '0;
            if (cp < 21'h80) begin
                g.count    = 3'd1;
                g.bytes[0] = cp[7:0];
            end else if (cp < 21'h800) begin
                g.count    = 3'd2;
                g.bytes[0] = {3'b110, cp[10:6]};
                g.bytes[1] = {2'b10, cp[5:0]};
            end else if (cp < 21'h10000) begin
                g.count    = 3'd3;
                g.bytes[0] = {4'b1110, cp[15:12]};
                g.bytes[1] = {2'b10, cp[11:6]};
                g.bytes[2] = {2'b10, cp[5:0]};
            end else begin
                g.count    = 3'd4;
                g.bytes[0] = {5'b11110, cp[20:18]};
                g.bytes[1] = {2'b10, cp[17:12]};
                g.bytes[2] = {2'b10, cp[11:6]};
                g.bytes[3] = {2'b10, cp[5:0]};
            end
            return g;
        end
    endfunction

endpackage

@@ hw/rtl/jsu_front.sv @@
`timescale 1ns / 1ps

module jsu_front #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    input  logic [7:0]         in_byte,
    input  logic               in_end,
    input  logic               q_full,
    output logic               in_ready,
    output logic               push,
    output jsu_pkg::jsu_group_t push_group
);
    import jsu_pkg::*;

    localparam int SUMW = ((COUNT_WIDTH > 16) ? COUNT_WIDTH : 16) + 2;
    localparam logic [SUMW-1:0] CAP_LIMIT = SUMW'(1) << COUNT_WIDTH;

    typedef enum logic [5:0] {
        PH_PLAIN    = 6'b000001,
        PH_ESC      = 6'b000010,
        PH_HEX_HIGH = 6'b000100,
        PH_WANT_BS  = 6'b001000,
        PH_WANT_U   = 6'b010000,
        PH_HEX_LOW  = 6'b100000
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [1:0]             hexcnt_reg, hexcnt_next;
    logic [15:0]            high_reg, high_next;
    logic [15:0]            low_reg, low_next;
    logic [COUNT_WIDTH-1:0] wcount_reg, wcount_next;
    logic                   failed_reg, failed_next;
    logic [15:0]            cap_reg;

    logic                   accept;
    logic [4:0]             hexv;
    logic [8:0]             escv;
    logic [15:0]            unit_new;
    logic [20:0]            cp;
    logic                   cp_take;
    jsu_group_t             enc;
    jsu_group_t             grp;
    logic [SUMW-1:0]        cap_ext, cap_eff;
    logic [SUMW-1:0]        need;
    logic                   room;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign hexv     = hex_value(in_byte);
    assign escv     = simple_escape(in_byte);
    assign unit_new = (phase_reg == PH_HEX_LOW) ? {low_reg[11:0], hexv[3:0]}
                                                : {high_reg[11:0], hexv[3:0]};
    assign cp       = (phase_reg == PH_HEX_LOW)
                      ? 21'h10000 + {1'b0, high_reg[9:0], unit_new[9:0]}
                      : {5'd0, unit_new};
    assign enc      = utf8_encode(cp);

    assign cap_ext = SUMW'(cap_reg);
    assign cap_eff = (cap_ext > CAP_LIMIT) ? CAP_LIMIT : cap_ext;

    // bytes needed by whatever this item may emit
    always_comb
    begin
        if (phase_reg == PH_HEX_HIGH || phase_reg == PH_HEX_LOW)
            need = SUMW'(wcount_reg) + SUMW'(enc.count);
        else
            need = SUMW'(wcount_reg) + SUMW'(1);
    end
    assign room = need < cap_eff;

    always_comb
    begin
        phase_next  = phase_reg;
        hexcnt_next = hexcnt_reg;
        high_next   = high_reg;
        low_next    = low_reg;
        wcount_next = wcount_reg;
        failed_next = failed_reg;
        grp         = '0;
        cp_take     = 1'b0;

        if (in_end) begin
            grp.count     = 3'd1;
            grp.is_done   = 1'b1;
            grp.decode_ok = !failed_reg && (phase_reg == PH_PLAIN);
            phase_next    = PH_PLAIN;
            hexcnt_next   = 2'd0;
            high_next     = 16'd0;
            low_next      = 16'd0;
            wcount_next   = '0;
            failed_next   = 1'b0;
        end else if (!failed_reg) begin
            case (phase_reg)
                PH_PLAIN:
                begin
                    if (in_byte == CH_BSLASH)
                        phase_next = PH_ESC;
                    else if (room) begin
                        grp.count    = 3'd1;
                        grp.bytes[0] = in_byte;
                    end else
                        failed_next = 1'b1;
                end
                PH_ESC:
                begin
                    if (in_byte == CH_U) begin
                        phase_next  = PH_HEX_HIGH;
                        hexcnt_next = 2'd0;
                        high_next   = 16'd0;
                    end else if (!room || !escv[8]) begin
                        failed_next = 1'b1;
                        phase_next  = PH_PLAIN;
                    end else begin
                        grp.count    = 3'd1;
                        grp.bytes[0] = escv[7:0];
                        phase_next   = PH_PLAIN;
                    end
                end
                PH_HEX_HIGH:
                begin
                    if (!hexv[4]) begin
                        failed_next = 1'b1;
                        phase_next  = PH_PLAIN;
                        hexcnt_next = 2'd0;
                    end else begin
                        high_next   = unit_new;
                        hexcnt_next = hexcnt_reg + 2'd1;
                        if (hexcnt_reg == 2'd3) begin
                            if (unit_new inside {[16'hd800:16'hdbff]})
                                phase_next = PH_WANT_BS;
                            else if (unit_new inside {[16'hdc00:16'hdfff]}) begin
                                failed_next = 1'b1;
                                phase_next  = PH_PLAIN;
                            end else begin
                                phase_next = PH_PLAIN;
                                cp_take    = 1'b1;
                            end
                        end
                    end
                end
                PH_WANT_BS:
                begin
                    if (in_byte == CH_BSLASH)
                        phase_next = PH_WANT_U;
                    else begin
                        failed_next = 1'b1;
                        phase_next  = PH_PLAIN;
                        hexcnt_next = 2'd0;
                    end
                end
                PH_WANT_U:
                begin
                    if (in_byte == CH_U) begin
                        phase_next  = PH_HEX_LOW;
                        hexcnt_next = 2'd0;
                        low_next    = 16'd0;
                    end else begin
                        failed_next = 1'b1;
                        phase_next  = PH_PLAIN;
                        hexcnt_next = 2'd0;
                    end
                end
                PH_HEX_LOW:
                begin
                    if (!hexv[4]) begin
                        failed_next = 1'b1;
                        phase_next  = PH_PLAIN;
                        hexcnt_next = 2'd0;
                    end else begin
                        low_next    = unit_new;
                        hexcnt_next = hexcnt_reg + 2'd1;
                        if (hexcnt_reg == 2'd3) begin
                            phase_next = PH_PLAIN;
                            if (!(unit_new inside {[16'hdc00:16'hdfff]}) ||
                                !(high_reg inside {[16'hd800:16'hdbff]}))
                                failed_next = 1'b1;
                            else
                                cp_take = 1'b1;
                        end
                    end
                end
                default:
                begin
                    failed_next = 1'b1;
                    phase_next  = PH_PLAIN;
                    hexcnt_next = 2'd0;
                end
            endcase

            if (cp_take) begin
                if (room)
                    grp = enc;
                else
                    failed_next = 1'b1;
            end
            wcount_next = wcount_reg + COUNT_WIDTH'(grp.count);
        end
    end

    assign push       = accept && (grp.count != 3'd0);
    assign push_group = grp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg  <= PH_PLAIN;
            hexcnt_reg <= 2'd0;
            high_reg   <= 16'd0;
            low_reg    <= 16'd0;
            wcount_reg <= '0;
            failed_reg <= 1'b0;
            cap_reg    <= CAP_RESET;
        end else begin
            if (cfg_valid)
                cap_reg <= cfg_data;
            if (accept) begin
                phase_reg  <= phase_next;
                hexcnt_reg <= hexcnt_next;
                high_reg   <= high_next;
                low_reg    <= low_next;
                wcount_reg <= wcount_next;
                failed_reg <= failed_next;
            end
        end
    end

endmodule

@@ hw/rtl/jsu_queue.sv @@
`timescale 1ns / 1ps

module jsu_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  jsu_pkg::jsu_group_t push_group,
    input  logic                pop,
    output logic                full,
    output logic                q_valid,
    output jsu_pkg::jsu_group_t q_group
);
    import jsu_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    jsu_group_t    entry_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_pop;

    assign full    = (count_reg == CW'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_group = entry_reg[rd_ptr_reg];
    assign do_pop  = pop && q_valid;

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_group;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            if (push && !do_pop)
                count_reg <= count_reg + CW'(1);
            else if (!push && do_pop)
                count_reg <= count_reg - CW'(1);
        end
    end

endmodule

@@ hw/rtl/jsu_back.sv @@
`timescale 1ns / 1ps

module jsu_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  jsu_pkg::jsu_group_t q_group,
    output logic                pop,
    input  logic                out_ready,
    output logic                out_valid,
    output logic [7:0]          out_byte,
    output logic                out_done,
    output logic                out_ok,
    output logic                out_last
);
    import jsu_pkg::*;

    jsu_group_t cur_reg;
    logic       cur_valid_reg;
    logic [1:0] idx_reg;
    logic       oval_reg;
    logic [7:0] obyte_reg;
    logic       odone_reg, ook_reg, olast_reg;
    logic       out_free;
    logic       cur_last;
    logic       advance;

    assign out_free = !oval_reg || out_ready;
    assign cur_last = ({1'b0, idx_reg} == (cur_reg.count - 3'd1));
    assign advance  = out_free && cur_valid_reg;
    assign pop      = q_valid && (!cur_valid_reg || (advance && cur_last));

    assign out_valid = oval_reg;
    assign out_byte  = obyte_reg;
    assign out_done  = odone_reg;
    assign out_ok    = ook_reg;
    assign out_last  = olast_reg;

    always_ff @(posedge clk)
    begin
        if (pop)
            cur_reg <= q_group;
        if (advance) begin
            obyte_reg <= cur_reg.bytes[idx_reg];
            odone_reg <= cur_reg.is_done;
            ook_reg   <= cur_reg.decode_ok;
            olast_reg <= cur_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
            oval_reg      <= 1'b0;
        end else begin
            if (out_free)
                oval_reg <= cur_valid_reg;
            if (pop) begin
                cur_valid_reg <= 1'b1;
                idx_reg       <= 2'd0;
            end else if (advance) begin
                if (cur_last)
                    cur_valid_reg <= 1'b0;
                else
                    idx_reg <= idx_reg + 2'd1;
            end
        end
    end

endmodule

@@ hw/rtl/json_string_unescape_utf8_top.sv @@
`timescale 1ns / 1ps

// JSON string unescaper to UTF-8. Feed the raw bytes between the quotes, one
// per item, then an item with tlast high to close the string; that item gives
// one done item whose tuser carries the ok flag, and resets the decoder. The
// decoder takes one input item per cycle and files the bytes each item makes
// (zero to four) as one group in a four-entry queue; the output side sends one
// byte per cycle while m_tready is high, and input stalls only when the queue
// fills. Bytes pass through the queue, the current-group register and the
// output register. cfg_data sets the output capacity in bytes, one byte of it
// kept for a terminator that is never sent; write it only while idle.
module json_string_unescape_utf8_top #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,      // out_capacity
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,       // data_byte
    input  logic        s_tlast,       // end_of_string
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,       // out_byte
    output logic [1:0]  m_tuser,       // decode_ok, is_done
    output logic        m_tlast        // last_of_run
);
    import jsu_pkg::*;

    logic       push, pop, q_full, q_valid;
    jsu_group_t push_group, q_group;
    logic       out_done, out_ok;

    assign cfg_ready = 1'b1;
    assign m_tuser   = {out_ok, out_done};

    jsu_front #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .in_valid   (s_tvalid),
        .in_byte    (s_tdata),
        .in_end     (s_tlast),
        .q_full     (q_full),
        .in_ready   (s_tready),
        .push       (push),
        .push_group (push_group)
    );

    jsu_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_group (push_group),
        .pop        (pop),
        .full       (q_full),
        .q_valid    (q_valid),
        .q_group    (q_group)
    );

    jsu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_group   (q_group),
        .pop       (pop),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_byte  (m_tdata),
        .out_done  (out_done),
        .out_ok    (out_ok),
        .out_last  (m_tlast)
    );

endmodule

@@ test/json_string_unescape_utf8_checker.sv @@
`timescale 1ns / 1ps

module json_string_unescape_utf8_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [15:0] cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,
    input  logic [1:0]  m_tuser,
    input  logic        m_tlast,
    output int          fail_count,
    output int          pending_count
);

    import jsu_pkg::*;

    localparam logic [15:0] SURR_HIGH_MIN = 16'hd800;
    localparam logic [15:0] SURR_HIGH_MAX = 16'hdbff;
    localparam logic [15:0] SURR_LOW_MIN  = 16'hdc00;
    localparam logic [15:0] SURR_LOW_MAX  = 16'hdfff;

    typedef enum logic [2:0] {
        ST_PLAIN,
        ST_ESC,
        ST_HEX_HIGH,
        ST_WANT_BS,
        ST_WANT_U,
        ST_HEX_LOW
    } dec_state_t;

    typedef struct packed {
        logic [7:0] data;
        logic       done;
        logic       ok;
        logic       last;
    } out_item_t;

    out_item_t   utf8_q[$];
    logic [15:0] capacity;
    dec_state_t  st;
    logic [1:0]  digits;
    logic [15:0] hi_unit;
    logic [15:0] lo_unit;
    logic [15:0] written;
    logic        failed;
    int          errs;

    function automatic logic [3:0] hex_nibble(input logic [7:0] b, output logic good);
        logic [3:0] r;
        begin
            good = 1'b1;
            r = 4'd0;
            if (b >= "0" && b <= "9")
                r = 4'(b - "0");
            else if (b >= "a" && b <= "f")
                r = 4'(b - "a" + 8'd10);
            else if (b >= "A" && b <= "F")
                r = 4'(b - "A" + 8'd10);
            else
                good = 1'b0;
            return r;
        end
    endfunction

    function automatic logic [7:0] escape_target(input logic [7:0] b, output logic good);
        logic [7:0] r;
        begin
            good = 1'b1;
            case (b)
                "\"", "\\", "/": r = b;
                "b":             r = 8'h08;
                "f":             r = 8'h0c;
                "n":             r = 8'h0a;
                "r":             r = 8'h0d;
                "t":             r = 8'h09;
                default:
                begin
                    r = 8'h00;
                    good = 1'b0;
                end
            endcase
            return r;
        end
    endfunction

    // one byte of the capacity stays reserved for the terminator
    function automatic logic has_room(input int n);
        return (int'(written) + n) < int'(capacity);
    endfunction

    task automatic clear_decoder();
        st = ST_PLAIN;
        digits = 2'd0;
        hi_unit = 16'd0;
        lo_unit = 16'd0;
        written = 16'd0;
        failed = 1'b0;
    endtask

    task automatic set_failed();
        failed = 1'b1;
        st = ST_PLAIN;
        digits = 2'd0;
    endtask

    task automatic push_byte(input logic [7:0] v);
        out_item_t it;
        begin
            it = '0;
            it.data = v;
            utf8_q.push_back(it);
            written = written + 16'd1;
        end
    endtask

    // whole code point or nothing
    task automatic put_code_point(input logic [20:0] cp);
        int n;
        begin
            n = cp < 21'h80 ? 1 : cp < 21'h800 ? 2 : cp < 21'h10000 ? 3 : 4;
            if (!has_room(n))
                set_failed();
            else if (n == 1)
                push_byte(cp[7:0]);
            else if (n == 2)
            begin
                push_byte(8'(21'hc0 | (cp >> 6)));
                push_byte(8'(21'h80 | (cp & 21'h3f)));
            end
            else if (n == 3)
            begin
                push_byte(8'(21'he0 | (cp >> 12)));
                push_byte(8'(21'h80 | ((cp >> 6) & 21'h3f)));
                push_byte(8'(21'h80 | (cp & 21'h3f)));
            end
            else
            begin
                push_byte(8'(21'hf0 | (cp >> 18)));
                push_byte(8'(21'h80 | ((cp >> 12) & 21'h3f)));
                push_byte(8'(21'h80 | ((cp >> 6) & 21'h3f)));
                push_byte(8'(21'h80 | (cp & 21'h3f)));
            end
        end
    endtask

    task automatic predict_item(input logic [7:0] b, input logic eos);
        logic       good;
        logic [3:0] nib;
        logic [7:0] mapped;
        out_item_t  it;
        int         base;
        begin
            base = utf8_q.size();
            if (eos)
            begin
                it = '0;
                it.done = 1'b1;
                it.ok = !failed && st == ST_PLAIN;
                utf8_q.push_back(it);
                clear_decoder();
            end
            else if (!failed)
            begin
                case (st)
                    ST_PLAIN:
                        if (b == CH_BSLASH)
                            st = ST_ESC;
                        else if (has_room(1))
                            push_byte(b);
                        else
                            set_failed();
                    ST_ESC:
                        if (b == CH_U)
                        begin
                            st = ST_HEX_HIGH;
                            digits = 2'd0;
                            hi_unit = 16'd0;
                        end
                        else
                        begin
                            mapped = escape_target(b, good);
                            if (!has_room(1) || !good)
                                set_failed();
                            else
                            begin
                                push_byte(mapped);
                                st = ST_PLAIN;
                            end
                        end
                    ST_HEX_HIGH:
                    begin
                        nib = hex_nibble(b, good);
                        if (!good)
                            set_failed();
                        else
                        begin
                            hi_unit = {hi_unit[11:0], nib};
                            if (digits < 2'd3)
                                digits = digits + 2'd1;
                            else
                            begin
                                digits = 2'd0;
                                if (hi_unit >= SURR_HIGH_MIN && hi_unit <= SURR_HIGH_MAX)
                                    st = ST_WANT_BS;
                                else if (hi_unit >= SURR_LOW_MIN && hi_unit <= SURR_LOW_MAX)
                                    set_failed();
                                else
                                begin
                                    st = ST_PLAIN;
                                    put_code_point({5'd0, hi_unit});
                                end
                            end
                        end
                    end
                    ST_WANT_BS:
                        if (b == CH_BSLASH)
                            st = ST_WANT_U;
                        else
                            set_failed();
                    ST_WANT_U:
                        if (b == CH_U)
                        begin
                            st = ST_HEX_LOW;
                            digits = 2'd0;
                            lo_unit = 16'd0;
                        end
                        else
                            set_failed();
                    ST_HEX_LOW:
                    begin
                        nib = hex_nibble(b, good);
                        if (!good)
                            set_failed();
                        else
                        begin
                            lo_unit = {lo_unit[11:0], nib};
                            if (digits < 2'd3)
                                digits = digits + 2'd1;
                            else
                            begin
                                digits = 2'd0;
                                if (lo_unit < SURR_LOW_MIN || lo_unit > SURR_LOW_MAX)
                                    set_failed();
                                else
                                begin
                                    st = ST_PLAIN;
                                    put_code_point(21'h10000
                                        + (21'(hi_unit - SURR_HIGH_MIN) << 10)
                                        + 21'(lo_unit - SURR_LOW_MIN));
                                end
                            end
                        end
                    end
                    default:
                        set_failed();
                endcase
            end
            if (utf8_q.size() > base)
            begin
                it = utf8_q.pop_back();
                it.last = 1'b1;
                utf8_q.push_back(it);
            end
        end
    endtask

    task automatic check_item();
        out_item_t want;
        begin
            if (utf8_q.size() == 0)
            begin
                errs++;
                $display("%0t: unexpected item: byte %02h done %0b ok %0b last %0b", $time,
                         m_tdata, m_tuser[0], m_tuser[1], m_tlast);
            end
            else
            begin
                want = utf8_q.pop_front();
                if (want.data !== m_tdata || want.done !== m_tuser[0]
                    || want.ok !== m_tuser[1] || want.last !== m_tlast)
                begin
                    errs++;
                    $display("%0t: mismatch: expected byte %02h done %0b ok %0b last %0b, %s",
                             $time, want.data, want.done, want.ok, want.last,
                             $sformatf("got byte %02h done %0b ok %0b last %0b",
                                       m_tdata, m_tuser[0], m_tuser[1], m_tlast));
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            utf8_q.delete();
            capacity = CAP_RESET;
            clear_decoder();
            errs = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                capacity = cfg_data;
            if (s_tvalid && s_tready)
                predict_item(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
                check_item();
        end
        fail_count <= errs;
        pending_count <= utf8_q.size();
    end

endmodule

@@ test/json_string_unescape_utf8_top_tb.sv @@
`timescale 1ns / 1ps

module json_string_unescape_utf8_top_tb;

    import jsu_pkg::*;

    localparam int ITEMS_PER_PHASE = 24;
    localparam int HOLD_CYCLES = 8;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    int          fail_count;
    int          pending_count;
    int          items_sent = 0;
    bit          quiet = 1'b0;
    logic [7:0]  str_q[$];

    json_string_unescape_utf8_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    json_string_unescape_utf8_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tlast       (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #3000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic int draw_gap();
        if (quiet || $urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, 15);
    endfunction

    function automatic logic [7:0] esc_letter(input int idx);
        case (idx)
            0:       return "\"";
            1:       return "\\";
            2:       return "/";
            3:       return "b";
            4:       return "f";
            5:       return "n";
            6:       return "r";
            default: return "t";
        endcase
    endfunction

    function automatic logic is_escape_letter(input logic [7:0] b);
        for (int i = 0; i < 8; i++)
            if (esc_letter(i) == b)
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic logic is_hex_char(input logic [7:0] b);
        return (b >= "0" && b <= "9") || (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10)
            return 8'("0" + n);
        return 8'(($urandom_range(0, 1) ? "a" : "A") + n - 10);
    endfunction

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        begin
            do
                b = 8'($urandom_range(0, 255));
            while (b == CH_BSLASH);
            return b;
        end
    endfunction

    function automatic logic [7:0] non_hex_byte();
        logic [7:0] b;
        begin
            do
                b = 8'($urandom_range(0, 255));
            while (is_hex_char(b));
            return b;
        end
    endfunction

    function automatic logic [7:0] bad_letter();
        logic [7:0] b;
        begin
            do
                b = 8'($urandom_range(0, 255));
            while (is_escape_letter(b) || b == CH_U);
            return b;
        end
    endfunction

    // any non-surrogate unit, weighted by UTF-8 length, plus range edges
    function automatic logic [15:0] bmp_unit();
        case ($urandom_range(0, 4))
            0: return 16'($urandom_range(16'h0000, 16'h007f));
            1: return 16'($urandom_range(16'h0080, 16'h07ff));
            2: return 16'($urandom_range(16'h0800, 16'hd7ff));
            3: return 16'($urandom_range(16'he000, 16'hffff));
            default:
                case ($urandom_range(0, 5))
                    0:       return 16'h0000;
                    1:       return 16'h007f;
                    2:       return 16'h0080;
                    3:       return 16'h07ff;
                    4:       return 16'h0800;
                    default: return 16'hffff;
                endcase
        endcase
    endfunction

    function automatic logic [15:0] high_surrogate();
        return 16'($urandom_range(16'hd800, 16'hdbff));
    endfunction

    function automatic logic [15:0] low_surrogate();
        return 16'($urandom_range(16'hdc00, 16'hdfff));
    endfunction

    task automatic add_byte(input logic [7:0] b);
        str_q.push_back(b);
    endtask

    task automatic add_escape(input logic [7:0] letter);
        str_q.push_back(CH_BSLASH);
        str_q.push_back(letter);
    endtask

    task automatic add_unit(input logic [15:0] u);
        str_q.push_back(CH_BSLASH);
        str_q.push_back(CH_U);
        str_q.push_back(hex_char(u[15:12]));
        str_q.push_back(hex_char(u[11:8]));
        str_q.push_back(hex_char(u[7:4]));
        str_q.push_back(hex_char(u[3:0]));
    endtask

    task automatic build_random_string();
        int         ntok;
        int         kind;
        int         mark;
        int         cut;
        logic [7:0] b;
        begin
            str_q.delete();
            ntok = $urandom_range(1, 5);
            for (int i = 0; i < ntok; i++)
            begin
                kind = $urandom_range(0, 99);
                if (kind < 30)
                    add_byte(plain_byte());
                else if (kind < 45)
                    add_escape(esc_letter($urandom_range(0, 7)));
                else if (kind < 70)
                    add_unit(bmp_unit());
                else if (kind < 84)
                begin
                    add_unit(high_surrogate());
                    add_unit(low_surrogate());
                end
                else if (kind < 88)
                    add_unit(low_surrogate());
                else if (kind < 93)
                begin
                    // high surrogate not followed by a proper low one
                    add_unit(high_surrogate());
                    case ($urandom_range(0, 2))
                        0: add_byte(plain_byte());
                        1:
                        begin
                            do
                                b = 8'($urandom_range(0, 255));
                            while (b == CH_U);
                            add_escape(b);
                        end
                        default:
                            add_unit($urandom_range(0, 1)
                                     ? 16'($urandom_range(16'h0000, 16'hdbff))
                                     : 16'($urandom_range(16'he000, 16'hffff)));
                    endcase
                end
                else if (kind < 96)
                    add_escape(bad_letter());
                else
                begin
                    add_byte(CH_BSLASH);
                    add_byte(CH_U);
                    repeat ($urandom_range(0, 3))
                        add_byte(hex_char(4'($urandom_range(0, 15))));
                    add_byte(non_hex_byte());
                end
            end
            // string cut off inside an escape
            if ($urandom_range(0, 7) == 0)
            begin
                mark = str_q.size();
                if ($urandom_range(0, 1))
                    add_unit(bmp_unit());
                else
                begin
                    add_unit(high_surrogate());
                    add_unit(low_surrogate());
                end
                cut = $urandom_range(1, str_q.size() - mark - 1);
                repeat (cut)
                    void'(str_q.pop_back());
            end
        end
    endtask

    task automatic send_item(input logic [7:0] b, input logic eos);
        int gap;
        begin
            gap = draw_gap();
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata <= b;
            s_tlast <= eos;
            do
                @(posedge clk);
            while (!s_tready);
            items_sent++;
        end
    endtask

    task automatic send_string();
        foreach (str_q[i])
            send_item(str_q[i], 1'b0);
        send_item(8'($urandom_range(0, 255)), 1'b1);
        str_q.delete();
    endtask

    // pending count is registered and trails the accepting edge
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (HOLD_CYCLES) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [15:0] cap);
        cfg_data <= cap;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int pause;
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            pause = draw_gap();
            if (pause > 0)
            begin
                m_tready <= 1'b0;
                repeat (pause) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    initial
    begin
        logic [15:0] cap;
        int          phase_start;
        rst_n <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data <= 16'd0;
        s_tvalid <= 1'b0;
        s_tdata <= 8'd0;
        s_tlast <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // byte extremes, simple escapes, surrogate pair, unknown escape
        add_byte(8'h00);
        add_byte(8'hff);
        add_byte("A");
        send_string();
        add_escape("t");
        add_escape("/");
        send_string();
        add_unit(16'hd83d);
        add_unit(16'hde00);
        send_string();
        add_escape("x");
        send_string();

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0:       cap = 16'd1;
                1:       cap = 16'hffff;
                2:       cap = 16'd0;
                3:       cap = 16'($urandom_range(2, 9));
                4:       cap = 16'($urandom_range(3, 14));
                default: cap = CAP_RESET;
            endcase
            wait_idle();
            write_capacity(cap);
            phase_start = items_sent;
            while (items_sent - phase_start < ITEMS_PER_PHASE)
            begin
                quiet = ($urandom_range(0, 3) == 0);
                build_random_string();
                send_string();
                if ($urandom_range(0, 7) == 0)
                    wait_idle();
            end
        end

        quiet = 1'b0;
        wait_idle();
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
